[rtl/rhl_pkg.sv]
// shared types and constants for the relay hysteresis channel
// used by rhl_eval and relay_hysteresis_logic_core; no dependencies
package rhl_pkg;

  localparam int VALUE_W     = 16;
  localparam int SENSOR_W    = 5;
  localparam int DWORD_W     = 2;
  localparam int MODE_W      = 3;
  localparam int LINK_W      = 4;
  localparam int FLAG_W      = 4;
  localparam int MAX_SOURCES = 4;
  localparam int SENSOR_COUNT = 32;
  localparam int CFG_IDX_W   = 3;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;

  // run modes; only AND, OR and LINK drive the relay, all other codes hold it
  localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AND    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OR     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LINK   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK   = 3'd6;

  // layout of one source select byte
  localparam int SEL_EN_BIT = 0;
  localparam int SEL_DW_LO  = 1;
  localparam int SEL_DW_HI  = 2;
  localparam int SEL_SN_LO  = 3;
  localparam int SEL_SN_HI  = 7;

  typedef struct packed {
    logic [VALUE_W-1:0] upper_limit;
    logic [VALUE_W-1:0] lower_limit;
    logic [VALUE_W-1:0] source_select_a;
    logic [VALUE_W-1:0] source_select_b;
    logic [MODE_W-1:0]  run_mode;
    logic               invert_polarity;
    logic [LINK_W-1:0]  link_input;
  } rhl_cfg_t;

  typedef struct packed {
    logic                kind;
    logic [SENSOR_W-1:0] sensor_index;
    logic [DWORD_W-1:0]  data_index;
    logic [VALUE_W-1:0]  sample_value;
    logic [VALUE_W-1:0]  din_bits;
  } rhl_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] source_flags;
    logic              relay_drive;
  } rhl_result_t;

endpackage

[rtl/relay_hysteresis_logic_core.sv]
// relay hysteresis channel: top level with config registers, state and output buffer
// depends on rhl_pkg and rhl_eval
//
// One relay channel. Items come in on the in_ stream: tuser = 0 is a sensor
// sample that latches into every source whose select byte names its sensor
// and data word; tuser = 1 evaluates the hysteresis flags, and in AND, OR and
// LINK modes also drives the relay. Every item gives exactly one result on the
// out_ stream: relay drive and the four source flags as they stand after that item.
// Each result is registered before out_tvalid. One item per cycle is sustained
// while the output is not stalled: the whole update is a single combinational
// pass from the state registers, and the state is written at the accept edge,
// so the next item sees it at once.
// A two-entry output buffer (result register plus skid register) lets an item
// be accepted while a result waits; in_tready drops only when both are full.
// Registers are written through cfg_we/cfg_index/cfg_wdata, by the user only while
// idle; the block does not enforce it. Reset (rst_n low, synchronous) clears all
// registers, source values, flags and the relay drive, and empties the output buffer.
module relay_hysteresis_logic_core import rhl_pkg::*; #(
  parameter int SOURCE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // sensor_index[4:0], data_index[6:5], sample_value[22:7], din_bits[38:23], zero[39]
  input  logic [39:0]          in_tdata,
  // kind[0]
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // relay_drive[0], source_flags[4:1], zero[7:5]
  output logic [7:0]           out_tdata
);

  localparam int ACT = (SOURCE_COUNT < MAX_SOURCES) ? SOURCE_COUNT : MAX_SOURCES;

  rhl_cfg_t           cfg_r;
  rhl_item_t          item;
  rhl_result_t        res;
  logic [VALUE_W-1:0] src_val_r   [ACT];
  logic [VALUE_W-1:0] src_val_nxt [ACT];
  logic [FLAG_W-1:0]  flags_r, flags_nxt;
  logic               relay_r, relay_nxt;
  logic               out_valid_r, skid_valid_r;
  rhl_result_t        out_data_r, skid_data_r;
  logic               in_fire;

  assign item.kind         = in_tuser;
  assign item.sensor_index = in_tdata[4:0];
  assign item.data_index   = in_tdata[6:5];
  assign item.sample_value = in_tdata[22:7];
  assign item.din_bits     = in_tdata[38:23];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER:  cfg_r.upper_limit     <= cfg_wdata;
        CFG_LOWER:  cfg_r.lower_limit     <= cfg_wdata;
        CFG_SEL_A:  cfg_r.source_select_a <= cfg_wdata;
        CFG_SEL_B:  cfg_r.source_select_b <= cfg_wdata;
        CFG_MODE:   cfg_r.run_mode        <= cfg_wdata[MODE_W-1:0];
        CFG_INVERT: cfg_r.invert_polarity <= cfg_wdata[0];
        CFG_LINK:   cfg_r.link_input      <= cfg_wdata[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  rhl_eval #(
    .SOURCE_COUNT(SOURCE_COUNT)
  ) u_eval (
    .cfg         (cfg_r),
    .item        (item),
    .src_val     (src_val_r),
    .flags       (flags_r),
    .relay       (relay_r),
    .src_val_nxt (src_val_nxt),
    .flags_nxt   (flags_nxt),
    .relay_nxt   (relay_nxt)
  );

  assign res.relay_drive  = relay_nxt;
  assign res.source_flags = flags_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ACT; s++) begin
        src_val_r[s] <= '0;
      end
      flags_r <= '0;
      relay_r <= 1'b0;
    end else if (in_fire) begin
      src_val_r <= src_val_nxt;
      flags_r   <= flags_nxt;
      relay_r   <= relay_nxt;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.source_flags, out_data_r.relay_drive};

endmodule

[rtl/rhl_eval.sv]
// next-state logic for one item: sample latching, hysteresis flags, relay drive
// depends on rhl_pkg
module rhl_eval import rhl_pkg::*; #(
  parameter int SOURCE_COUNT = 4
) (
  input  rhl_cfg_t           cfg,
  input  rhl_item_t          item,
  input  logic [VALUE_W-1:0] src_val [(SOURCE_COUNT < MAX_SOURCES) ? SOURCE_COUNT : MAX_SOURCES],
  input  logic [FLAG_W-1:0]  flags,
  input  logic               relay,
  output logic [VALUE_W-1:0] src_val_nxt [(SOURCE_COUNT < MAX_SOURCES) ? SOURCE_COUNT : MAX_SOURCES],
  output logic [FLAG_W-1:0]  flags_nxt,
  output logic               relay_nxt
);

  localparam int ACT = (SOURCE_COUNT < MAX_SOURCES) ? SOURCE_COUNT : MAX_SOURCES;
  localparam logic [FLAG_W-1:0] PRESENT = FLAG_W'((1 << ACT) - 1);

  logic [7:0]        sel_byte [ACT];
  logic [FLAG_W-1:0] enabled;
  logic [FLAG_W-1:0] eval_flags;
  logic              sensor_ok;
  logic              cond;

  assign sensor_ok = ({1'b0, item.sensor_index} < (SENSOR_W+1)'(SENSOR_COUNT));

  for (genvar s = 0; s < ACT; s++) begin : g_src
    logic [VALUE_W-1:0] word;
    logic               hit;
    assign word = (s < 2) ? cfg.source_select_a : cfg.source_select_b;
    assign sel_byte[s] = (s % 2 == 1) ? word[15:8] : word[7:0];
    assign hit = (item.kind == KIND_SAMPLE) && sensor_ok
                 && (sel_byte[s][SEL_SN_HI:SEL_SN_LO] == item.sensor_index)
                 && (sel_byte[s][SEL_DW_HI:SEL_DW_LO] == item.data_index);
    assign src_val_nxt[s] = hit ? item.sample_value : src_val[s];
  end

  always_comb begin
    enabled    = '0;
    eval_flags = flags;
    for (int s = 0; s < ACT; s++) begin
      enabled[s] = sel_byte[s][SEL_EN_BIT];
      // single mode tracks source 0 even when it is disabled
      if (sel_byte[s][SEL_EN_BIT] || (s == 0 && cfg.run_mode == MODE_SINGLE)) begin
        if (src_val[s] > cfg.upper_limit) begin
          eval_flags[s] = 1'b1;
        end else if (src_val[s] < cfg.lower_limit) begin
          eval_flags[s] = 1'b0;
        end
      end else if (cfg.run_mode == MODE_AND) begin
        eval_flags[s] = 1'b1;
      end else if (cfg.run_mode == MODE_OR) begin
        eval_flags[s] = 1'b0;
      end
    end
    eval_flags = eval_flags & PRESENT;
  end

  always_comb begin
    cond = 1'b0;
    if (cfg.run_mode == MODE_AND) begin
      cond = (eval_flags == PRESENT) && (enabled != '0);
    end else if (cfg.run_mode == MODE_OR) begin
      cond = (eval_flags != '0) && (enabled != '0);
    end else begin
      cond = item.din_bits[cfg.link_input];
    end
  end

  always_comb begin
    flags_nxt = flags;
    relay_nxt = relay;
    if (item.kind == KIND_EVAL) begin
      flags_nxt = eval_flags;
      if (cfg.run_mode == MODE_AND || cfg.run_mode == MODE_OR
          || cfg.run_mode == MODE_LINK) begin
        relay_nxt = cond ^ cfg.invert_polarity;
      end
    end
  end

endmodule
